// ===== design/abe_pkg.sv =====
// abe_pkg: command codes, register indexes, beat layouts and small helpers
// for the allocation bitmap engine. No dependencies.
package abe_pkg;

  localparam logic [2:0] CMD_TEST  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_COUNT = 3'd2;
  localparam logic [2:0] CMD_LOAD  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] REG_BLOCK_BYTES  = 2'd0;
  localparam logic [1:0] REG_TOTAL_BLOCKS = 2'd1;
  localparam logic [1:0] REG_BITMAP_COUNT = 2'd2;

  localparam logic [13:0] BLOCK_BYTES_RST  = 14'd512;
  localparam logic [17:0] TOTAL_BLOCKS_RST = 18'd1760;
  localparam logic [6:0]  BITMAP_COUNT_RST = 7'd1;

  // longword index is 13 bits wide, one quotient bit per divide step
  localparam int DIV_STEPS = 13;

  localparam int IN_BITS     = 66;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_BITS    = 74;
  localparam int OUT_TDATA_W = 80;

  // first member lands in the highest bits
  typedef struct packed {
    logic [31:0] word_data;
    logic [11:0] word_index;
    logic        bit_value;
    logic [17:0] block_number;
    logic [2:0]  command;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [17:0] free_count;
    logic [2:0]  bit_position;
    logic [12:0] byte_offset;
    logic [5:0]  map_block_index;
    logic        is_free;
    logic        found;
  } out_item_t;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < 32; i++) begin
      c = c + 6'(v[i]);
    end
    return c;
  endfunction

  // keep only the valid low bits of the final map longword
  function automatic logic [31:0] mask_tail(input logic [31:0] v, input logic last,
                                            input logic [4:0] rem);
    logic [31:0] m;
    m = (32'd1 << rem) - 32'd1;
    if (last && (rem != 5'd0)) begin
      return v & m;
    end
    return v;
  endfunction

endpackage

// ===== design/allocation_bitmap_engine.sv =====
// allocation_bitmap_engine: block-allocation bitmap store with test, write-bit,
// count-free, load-word and read-word commands. Depends on abe_pkg.

// The bitmap lives in one MAP_WORDS x 32 memory (1 = free, bit i of longword w
// is disk block 2 + 32*w + i). After reset a clearing pass writes every word
// to zero, one per cycle, while s_tready stays low; config
// writes are taken during that pass. Then one beat is handled at a time.
// Test and write-bit run a 13-step restoring divider (one quotient bit per
// cycle) that splits the longword index by the longwords per bitmap block.
// Count-free streams min(L, A) longwords through the memory read port and a
// popcount stage, where L is the serialized map length and A the available
// storage. The result sits in an output register, so the next beat is
// accepted while a result still waits on m_tready.
module allocation_bitmap_engine #(
  parameter int MAP_WORDS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [17:0]                     cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // command, block_number, bit_value, word_index, word_data, zero pad
  input  logic [abe_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // found, is_free, map_block_index, byte_offset, bit_position, free_count,
  // read_data, zero pad
  output logic [abe_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [17:0] MAP_LIMIT = 18'(MAP_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_LOC   = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_CNT   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [AW-1:0] clr_idx;

  // configuration
  logic [13:0] block_bytes;
  logic [17:0] total_blocks;
  logic [6:0]  bitmap_block_count;

  // derived sizes, refreshed every cycle
  logic [11:0] bq, bcl;
  logic [10:0] wpb_c;
  logic [6:0]  bbc_c;
  logic [17:0] prod_c;
  logic [17:0] bits_c;
  logic [18:0] bits_up_c;
  logic [10:0] wpb;
  logic [16:0] a_words;
  logic [13:0] l_words;
  logic [4:0]  rem_bits;

  // latched beat
  abe_pkg::in_item_t in_c;
  logic [2:0]  cmd;
  logic [17:0] nr;
  logic        val;
  logic [11:0] wi;
  logic [31:0] wd;

  // locate
  logic [17:0] n_c;
  logic [12:0] word_c;
  logic [16:0] word_ext_c, wi_ext_c, len_c;
  logic        blk_ok, load_ok, read_ok, wi_last;
  logic [12:0] word;
  logic [4:0]  bitw;

  // divider
  logic [12:0] div_q;
  logic [10:0] div_r;
  logic [3:0]  div_cnt;
  logic [11:0] div_sh;
  logic        div_ge;

  // count pipeline
  logic [16:0] len_words, issue_idx, pidx;
  logic        issuing, pv, pcv;
  logic [5:0]  pc;
  logic [17:0] sum;

  // memory
  logic [31:0]   mem [MAP_WORDS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata, bit_mask;

  abe_pkg::out_item_t res;

  assign s_tready = (state == S_IDLE);
  assign in_c = s_tdata[abe_pkg::IN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes        <= abe_pkg::BLOCK_BYTES_RST;
      total_blocks       <= abe_pkg::TOTAL_BLOCKS_RST;
      bitmap_block_count <= abe_pkg::BITMAP_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abe_pkg::REG_BLOCK_BYTES:  block_bytes        <= cfg_data[13:0];
        abe_pkg::REG_TOTAL_BLOCKS: total_blocks       <= cfg_data;
        abe_pkg::REG_BITMAP_COUNT: bitmap_block_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bq        = block_bytes[13:2];
    bcl       = (bq > 12'd2048) ? 12'd2048 : bq;
    wpb_c     = (bcl >= 12'd2) ? 11'(bcl - 12'd1) : 11'd0;
    bbc_c     = (bitmap_block_count > 7'd64) ? 7'd64 : bitmap_block_count;
    prod_c    = 18'(bbc_c) * 18'(wpb_c);
    bits_c    = (total_blocks < 18'd2) ? 18'd0 : total_blocks - 18'd2;
    bits_up_c = 19'(bits_c) + 19'd31;
  end

  always_ff @(posedge clk) begin
    wpb      <= wpb_c;
    a_words  <= (prod_c > MAP_LIMIT) ? MAP_LIMIT[16:0] : prod_c[16:0];
    l_words  <= bits_up_c[18:5];
    rem_bits <= bits_c[4:0];
  end

  always_comb begin
    n_c        = nr - 18'd2;
    word_c     = n_c[17:5];
    word_ext_c = {4'd0, word_c};
    wi_ext_c   = {5'd0, wi};
    len_c      = ({3'd0, l_words} < a_words) ? {3'd0, l_words} : a_words;
    blk_ok     = (nr >= 18'd2) && (nr < total_blocks) && (word_ext_c < a_words);
    load_ok    = wi_ext_c < a_words;
    read_ok    = wi_ext_c < len_c;
    wi_last    = (wi_ext_c + 17'd1) == {3'd0, l_words};
    issuing    = issue_idx < len_words;
    div_sh     = {div_r, div_q[12]};
    div_ge     = div_sh >= {1'b0, wpb};
  end

  // memory port selection
  always_comb begin
    bit_mask  = 32'd1 << bitw;
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = word_ext_c[AW-1:0];
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_PREP && cmd == abe_pkg::CMD_LOAD && load_ok) begin
      mem_we    = 1'b1;
      mem_waddr = wi_ext_c[AW-1:0];
      mem_wdata = wd;
    end else if (state == S_LOC && cmd == abe_pkg::CMD_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(word);
      mem_wdata = val ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
    end
    if (state == S_PREP) begin
      mem_re    = 1'b1;
      mem_raddr = (cmd == abe_pkg::CMD_READ) ? wi_ext_c[AW-1:0] : word_ext_c[AW-1:0];
    end else if (state == S_CNT) begin
      mem_re    = issuing;
      mem_raddr = issue_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
      pv       <= 1'b0;
      pcv      <= 1'b0;
      res      <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= in_c.command;
            nr    <= in_c.block_number;
            val   <= in_c.bit_value;
            wi    <= in_c.word_index;
            wd    <= in_c.word_data;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          word      <= word_c;
          bitw      <= n_c[4:0];
          div_q     <= word_c;
          div_r     <= '0;
          div_cnt   <= '0;
          len_words <= len_c;
          issue_idx <= '0;
          sum       <= '0;
          pv        <= 1'b0;
          pcv       <= 1'b0;
          case (cmd)
            abe_pkg::CMD_TEST, abe_pkg::CMD_WRITE: begin
              state <= blk_ok ? S_DIV : S_OUT;
            end
            abe_pkg::CMD_COUNT: begin
              res.found <= 1'b1;
              state     <= (len_c != 17'd0) ? S_CNT : S_OUT;
            end
            abe_pkg::CMD_LOAD: begin
              res.found <= load_ok;
              state     <= S_OUT;
            end
            abe_pkg::CMD_READ: begin
              state <= read_ok ? S_RDW : S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_DIV: begin
          div_r   <= div_ge ? 11'(div_sh - {1'b0, wpb}) : div_sh[10:0];
          div_q   <= {div_q[11:0], div_ge};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(abe_pkg::DIV_STEPS - 1)) begin
            state <= S_LOC;
          end
        end
        S_LOC: begin
          res.found           <= 1'b1;
          res.is_free         <= (cmd == abe_pkg::CMD_WRITE) ? val : mem_rdata[bitw];
          res.map_block_index <= div_q[5:0];
          // longword bytes are stored big-endian, past the checksum longword
          res.byte_offset     <= {div_r, ~bitw[4:3]} + 13'd4;
          res.bit_position    <= bitw[2:0];
          state               <= S_OUT;
        end
        S_RDW: begin
          res.found     <= 1'b1;
          res.read_data <= abe_pkg::mask_tail(mem_rdata, wi_last, rem_bits);
          state         <= S_OUT;
        end
        S_CNT: begin
          if (issuing) begin
            issue_idx <= issue_idx + 17'd1;
          end
          pv   <= issuing;
          pidx <= issue_idx;
          pcv  <= pv;
          pc   <= abe_pkg::popcount32(abe_pkg::mask_tail(mem_rdata,
                    (pidx + 17'd1) == {3'd0, l_words}, rem_bits));
          if (pcv) begin
            sum <= sum + 18'(pc);
          end
          if (!issuing && !pv && !pcv) begin
            res.free_count <= sum;
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(abe_pkg::OUT_TDATA_W - abe_pkg::OUT_BITS){1'b0}}, res};
            // result register starts empty for the next beat
            res      <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/allocation_bitmap_engine_tb.sv =====
// allocation_bitmap_engine_tb: self-checking testbench for the allocation bitmap engine.
// A shadow bitmap and geometry predict every result beat, which is checked field by field.
// Depends on abe_pkg and allocation_bitmap_engine.
module allocation_bitmap_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_DEPTH = 4096;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [abe_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [abe_pkg::OUT_TDATA_W-1:0] m_tdata;

  // shadow of the block state and geometry registers
  logic [31:0] bitmap_shadow [MAP_DEPTH];
  logic [13:0] geo_block_bytes;
  logic [17:0] geo_total_blocks;
  logic [6:0]  geo_bitmap_blocks;

  abe_pkg::out_item_t replies_due [$];
  int fault_count = 0;
  int count_budget = 70;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;

  allocation_bitmap_engine #(.MAP_WORDS(MAP_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned longwords_per_block();
    int unsigned b;
    b = geo_block_bytes;
    b = b & 32'hFFFF_FFFC;
    if (b > 8192) b = 8192;
    if (b < 8) return 0;
    return (b - 4) / 4;
  endfunction

  function automatic int unsigned avail_longwords();
    int unsigned n, a;
    n = geo_bitmap_blocks;
    if (n > 64) n = 64;
    a = n * longwords_per_block();
    if (a > MAP_DEPTH) a = MAP_DEPTH;
    return a;
  endfunction

  function automatic int unsigned map_bit_count();
    int unsigned t;
    t = geo_total_blocks;
    return (t < 2) ? 0 : t - 2;
  endfunction

  function automatic int unsigned serial_len();
    return (map_bit_count() + 31) / 32;
  endfunction

  function automatic int unsigned readable_len();
    int unsigned len;
    len = serial_len();
    if (len > avail_longwords()) len = avail_longwords();
    return len;
  endfunction

  // only the final serialized longword loses its unused high bits
  function automatic logic [31:0] visible_word(input int unsigned w);
    logic [31:0] v;
    int unsigned rem;
    v = bitmap_shadow[w];
    rem = map_bit_count() % 32;
    if (w + 1 == serial_len() && rem != 0) v = v & ((32'd1 << rem) - 32'd1);
    return v;
  endfunction

  function automatic abe_pkg::out_item_t apply_bitmap_command(input abe_pkg::in_item_t it);
    abe_pkg::out_item_t r;
    int unsigned nr, n, wpb, word, bitw, span, rb, sum;
    r = '0;
    wpb = longwords_per_block();
    case (it.command)
      abe_pkg::CMD_TEST, abe_pkg::CMD_WRITE: begin
        nr = it.block_number;
        if (nr >= 2 && nr < int'(geo_total_blocks) && wpb != 0) begin
          n = nr - 2;
          word = n / 32;
          bitw = n % 32;
          if (word < avail_longwords()) begin
            if (it.command == abe_pkg::CMD_WRITE) bitmap_shadow[word][bitw] = it.bit_value;
            span = wpb * 32;
            rb = (n % span) / 8;
            r.found = 1'b1;
            r.is_free = bitmap_shadow[word][bitw];
            r.map_block_index = 6'(n / span);
            // longwords are stored big-endian behind the checksum
            r.byte_offset = 13'((rb & 32'hFFFF_FFFC) + (3 - (rb & 3)) + 4);
            r.bit_position = 3'((n % span) % 8);
          end
        end
      end
      abe_pkg::CMD_COUNT: begin
        sum = 0;
        for (int unsigned w = 0; w < readable_len(); w++) sum += $countones(visible_word(w));
        r.found = 1'b1;
        r.free_count = 18'(sum);
      end
      abe_pkg::CMD_LOAD: begin
        if (it.word_index < avail_longwords()) begin
          bitmap_shadow[it.word_index] = it.word_data;
          r.found = 1'b1;
        end
      end
      abe_pkg::CMD_READ: begin
        if (it.word_index < readable_len()) begin
          r.found = 1'b1;
          r.read_data = visible_word(it.word_index);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    abe_pkg::out_item_t seen, want;
    if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
      seen = m_tdata[abe_pkg::OUT_BITS-1:0];
      if (replies_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected result beat %h", m_tdata);
      end else begin
        want = replies_due.pop_front();
        if (seen.found !== want.found || seen.is_free !== want.is_free ||
            seen.map_block_index !== want.map_block_index ||
            seen.byte_offset !== want.byte_offset ||
            seen.bit_position !== want.bit_position ||
            seen.free_count !== want.free_count || seen.read_data !== want.read_data) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("result mismatch");
            $display("  exp found=%0d free=%0d mblk=%0d boff=%0d bpos=%0d cnt=%0d rd=%h",
                     want.found, want.is_free, want.map_block_index, want.byte_offset,
                     want.bit_position, want.free_count, want.read_data);
            $display("  got found=%0d free=%0d mblk=%0d boff=%0d bpos=%0d cnt=%0d rd=%h",
                     seen.found, seen.is_free, seen.map_block_index, seen.byte_offset,
                     seen.bit_position, seen.free_count, seen.read_data);
          end
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_request(input abe_pkg::in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(abe_pkg::IN_TDATA_W-abe_pkg::IN_BITS){1'b0}}, it};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    replies_due.insert(replies_due.size(), apply_bitmap_command(it));
    @(negedge clk);
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (replies_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_geometry(input logic [13:0] bb, input logic [17:0] tb,
                              input logic [6:0] bc);
    quiesce();
    cfg_we <= 1'b1;
    cfg_index <= abe_pkg::REG_BLOCK_BYTES;
    cfg_data <= 18'(bb);
    @(negedge clk);
    cfg_index <= abe_pkg::REG_TOTAL_BLOCKS;
    cfg_data <= tb;
    @(negedge clk);
    cfg_index <= abe_pkg::REG_BITMAP_COUNT;
    cfg_data <= 18'(bc);
    @(negedge clk);
    cfg_we <= 1'b0;
    geo_block_bytes = bb;
    geo_total_blocks = tb;
    geo_bitmap_blocks = bc;
  endtask

  task automatic random_geometry();
    logic [13:0] bb;
    logic [17:0] tb;
    logic [6:0] bc;
    int unsigned pick, cap;
    pick = $urandom_range(99);
    if (pick < 70) bb = 14'(4 * $urandom_range(130, 2));
    else if (pick < 85) bb = 14'(4 * $urandom_range(2048, 2));
    else bb = 14'($urandom_range(16383, 0));
    pick = $urandom_range(99);
    if (pick < 70) bc = 7'($urandom_range(8, 0));
    else if (pick < 90) bc = 7'($urandom_range(64, 0));
    else bc = 7'($urandom_range(127, 0));
    // rough size of the storage so most volumes fit around it
    cap = 32 * ((bc > 64) ? 64 : bc) * (bb / 4) + 66;
    if (cap > 131074) cap = 131074;
    pick = $urandom_range(99);
    if (pick < 65) tb = 18'($urandom_range(cap, 2));
    else if (pick < 95) tb = 18'($urandom_range(131074, 0));
    else tb = 18'($urandom_range(18'h3FFFF, 0));
    set_geometry(bb, tb, bc);
  endtask

  function automatic abe_pkg::in_item_t mk_request(input logic [2:0] cmd, input int unsigned nr,
                                                   input logic val, input int unsigned wi,
                                                   input logic [31:0] wd);
    abe_pkg::in_item_t it;
    it.command = cmd;
    it.block_number = 18'(nr);
    it.bit_value = val;
    it.word_index = 12'(wi);
    it.word_data = wd;
    return it;
  endfunction

  function automatic abe_pkg::in_item_t random_request();
    abe_pkg::in_item_t it;
    int unsigned pick, avail, len, hi, nr, wi, bound;
    avail = avail_longwords();
    len = readable_len();
    pick = $urandom_range(99);
    if (pick < 28) it.command = abe_pkg::CMD_TEST;
    else if (pick < 58) it.command = abe_pkg::CMD_WRITE;
    else if (pick < 72) it.command = abe_pkg::CMD_LOAD;
    else if (pick < 91) it.command = abe_pkg::CMD_READ;
    else if (pick < 94) it.command = abe_pkg::CMD_COUNT;
    else it.command = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    if (it.command == abe_pkg::CMD_COUNT) begin
      if (count_budget > 0) count_budget--;
      else it.command = abe_pkg::CMD_READ;
    end
    // highest block that has a bit in storage
    hi = (geo_total_blocks < 2) ? 0 : geo_total_blocks - 1;
    if (32 * avail + 1 < hi) hi = 32 * avail + 1;
    pick = $urandom_range(99);
    if (pick < 75 && hi >= 2 && longwords_per_block() != 0) nr = $urandom_range(hi, 2);
    else if (pick < 88) begin
      case ($urandom_range(4))
        0: nr = 0;
        1: nr = 1;
        2: nr = geo_total_blocks - 1;
        3: nr = geo_total_blocks;
        default: nr = hi + 1;
      endcase
    end else nr = $urandom_range(18'h3FFFF, 0);
    bound = ((it.command == abe_pkg::CMD_LOAD) ? avail : len) + 1;
    if (bound > 4095) bound = 4095;
    pick = $urandom_range(99);
    if (pick < 15 && len > 0) wi = len - 1;
    else if (pick < 80) wi = $urandom_range(bound, 0);
    else wi = $urandom_range(4095, 0);
    pick = $urandom_range(99);
    it.block_number = 18'(nr);
    it.bit_value = 1'($urandom_range(1, 0));
    it.word_index = 12'(wi);
    it.word_data = (pick < 10) ? 32'hFFFF_FFFF : (pick < 20) ? 32'h0 : $urandom;
    return it;
  endfunction

  task automatic run_burst(input int n);
    repeat (n) send_request(random_request());
  endtask

  task automatic set_idling(input int sender, input int receiver);
    sender_idle_pct = sender;
    recv_stall_pct = receiver;
  endtask

  // reset geometry: 127 longwords of storage, 55 serialized, last one holds 30 bits
  task automatic test_directed_basics();
    set_idling(0, 0);
    send_request(mk_request(abe_pkg::CMD_TEST, 0, 1'b0, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_TEST, 1, 1'b0, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_TEST, 2, 1'b0, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_WRITE, 2, 1'b1, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_TEST, 2, 1'b0, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_WRITE, 1759, 1'b1, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_TEST, 1760, 1'b0, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_WRITE, 131073, 1'b1, 4095, 32'hFFFF_FFFF));
    send_request(mk_request(abe_pkg::CMD_WRITE, 0, 1'b1, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_LOAD, 0, 1'b0, 0, 32'hFFFF_FFFF));
    send_request(mk_request(abe_pkg::CMD_LOAD, 0, 1'b0, 54, 32'hFFFF_FFFF));
    send_request(mk_request(abe_pkg::CMD_LOAD, 0, 1'b0, 126, 32'hA5A5_A5A5));
    send_request(mk_request(abe_pkg::CMD_LOAD, 0, 1'b0, 127, 32'h1234_5678));
    send_request(mk_request(abe_pkg::CMD_LOAD, 0, 1'b0, 4095, 32'hFFFF_FFFF));
    send_request(mk_request(abe_pkg::CMD_READ, 0, 1'b0, 54, 32'h0));
    send_request(mk_request(abe_pkg::CMD_READ, 0, 1'b0, 55, 32'h0));
    send_request(mk_request(abe_pkg::CMD_READ, 0, 1'b0, 126, 32'h0));
    send_request(mk_request(abe_pkg::CMD_COUNT, 0, 1'b0, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_WRITE, 33, 1'b0, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_TEST, 33, 1'b0, 0, 32'h0));
    send_request(mk_request(CMD_SPARE_FIRST, 131073, 1'b1, 4095, 32'hFFFF_FFFF));
    send_request(mk_request(CMD_SPARE_MID, 5, 1'b0, 0, 32'h0));
    send_request(mk_request(CMD_SPARE_LAST, 2, 1'b1, 1, 32'h5A5A_5A5A));
    send_request(mk_request(abe_pkg::CMD_READ, 0, 1'b0, 0, 32'h0));
    send_request(mk_request(abe_pkg::CMD_COUNT, 0, 1'b0, 0, 32'h0));
  endtask

  task automatic test_geometry_corners();
    set_idling(0, 0);
    set_geometry(14'd8, 18'd2, 7'd0);
    run_burst(30);
    set_geometry(14'd8, 18'd66, 7'd64);
    run_burst(30);
    set_geometry(14'd8192, 18'd131074, 7'd64);
    run_burst(30);
    set_geometry(14'd16383, 18'd0, 7'd127);
    run_burst(30);
    set_geometry(14'd7, 18'd1760, 7'd1);
    run_burst(30);
    set_geometry(14'd13, 18'd100, 7'd3);
    run_burst(30);
    set_geometry(14'd512, 18'd1, 7'd1);
    run_burst(30);
    set_geometry(14'd4096, 18'd131073, 7'd2);
    run_burst(30);
    set_geometry(14'd16, 18'd40000, 7'd127);
    run_burst(30);
  endtask

  task automatic test_sender_gaps();
    set_idling(59, 0);
    repeat (8) begin
      random_geometry();
      run_burst(50);
    end
  endtask

  task automatic test_receiver_stalls();
    set_idling(0, 59);
    repeat (8) begin
      random_geometry();
      run_burst(50);
    end
  endtask

  task automatic test_both_idle();
    set_idling(29, 29);
    repeat (8) begin
      random_geometry();
      run_burst(50);
    end
  endtask

  task automatic test_drain_pauses();
    set_idling(29, 0);
    for (int i = 0; i < 12; i++) begin
      if (i % 4 == 0) random_geometry();
      run_burst(20);
      quiesce();
    end
  endtask

  task automatic test_steady_stream();
    set_idling(0, 0);
    repeat (3) begin
      random_geometry();
      run_burst(72);
    end
  endtask

  initial begin
    for (int w = 0; w < MAP_DEPTH; w++) bitmap_shadow[w] = '0;
    geo_block_bytes = abe_pkg::BLOCK_BYTES_RST;
    geo_total_blocks = abe_pkg::TOTAL_BLOCKS_RST;
    geo_bitmap_blocks = abe_pkg::BITMAP_COUNT_RST;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_geometry_corners();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_drain_pauses();
    test_steady_stream();
    quiesce();
    repeat (32) @(negedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
